// ===== hw/rtl/bbks_pkg.sv =====
// shared types, constants and helpers for the bounded best-k selector
// no dependencies; imported by bbks_cell, bounded_best_k_selector and its testbench
package bbks_pkg;

    localparam int MAX_CAPACITY = 16;
    localparam int CNT_W        = $clog2(MAX_CAPACITY + 1);
    localparam int IDX_W        = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int CAP_W        = 5;
    localparam int HELD_W       = 5;
    localparam int PEN_W        = 16;
    localparam int POS_W        = 32;
    localparam int PAY_W        = 64;
    localparam int KEY_W        = PEN_W + POS_W;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // cell operation codes
    localparam logic [1:0] OP_HOLD    = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_REPLACE = 2'd2;
    localparam logic [1:0] OP_SHIFT   = 2'd3;

    typedef struct packed {
        logic             cmd;
        logic [PEN_W-1:0] penalty;
        logic [POS_W-1:0] position;
        logic [PAY_W-1:0] payload;
    } in_word_t;

    typedef struct packed {
        logic              item_valid;
        logic              accepted;
        logic [PEN_W-1:0]  out_penalty;
        logic [POS_W-1:0]  out_position;
        logic [PAY_W-1:0]  out_payload;
        logic [HELD_W-1:0] held_count;
    } out_word_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } cell_ctrl_t;

    // zero reads as one, anything above the chain length as the chain length
    function automatic logic [CNT_W-1:0] cap_limit(input logic [CAP_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(v) > MAX_CAPACITY)
        begin
            r = CNT_W'(MAX_CAPACITY);
        end
        else
        begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bounded_best_k_selector.sv =====
// top level of the bounded best-k selector: controller, cell chain and output register
// depends on bbks_pkg and bbks_cell
//
// Keeps the best "capacity" candidates (lower penalty, then lower position, is better) in a
// chain of cells sorted worst-first, so the worst entry always sits in the head cell. Every
// word is first latched into the input registers; then, in the execute state, all cells
// compare against its key in parallel and shift, insert or close up by one place toward or
// away from the head. The input stalls during the execute state, which holds for as long as
// the previous result word still waits in the output register with the output stalled.
// Among equal keys the earliest inserted entry counts as worst. Writing capacity empties the
// store; a value of zero is taken as one and anything above the chain length as the chain
// length. There is no clearing pass after reset.
module bounded_best_k_selector
    import bbks_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_word
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;
    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0] pay_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_word_t        out_word_reg;
    out_word_t        out_word_next;

    logic             in_fire;
    logic             exec_done;
    cell_ctrl_t       ctrl;

    logic [KEY_W-1:0] cell_key [MAX_CAPACITY];
    logic [PAY_W-1:0] cell_pay [MAX_CAPACITY];
    logic             cell_ge  [MAX_CAPACITY];

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign exec_done = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CAPACITY; gi++)
        begin : g_cell
            logic             lft_ge;
            logic [KEY_W-1:0] lft_key;
            logic [PAY_W-1:0] lft_pay;
            logic             rgt_ge;
            logic [KEY_W-1:0] rgt_key;
            logic [PAY_W-1:0] rgt_pay;
            logic             slot_valid;

            assign slot_valid = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign lft_ge  = 1'b1;
                assign lft_key = ctrl.key;
                assign lft_pay = ctrl.payload;
            end
            else
            begin : g_body
                assign lft_ge  = cell_ge[gi-1];
                assign lft_key = cell_key[gi-1];
                assign lft_pay = cell_pay[gi-1];
            end

            if (gi == MAX_CAPACITY - 1)
            begin : g_tail
                assign rgt_ge  = 1'b0;
                assign rgt_key = cell_key[gi];
                assign rgt_pay = cell_pay[gi];
            end
            else
            begin : g_next
                assign rgt_ge  = cell_ge[gi+1];
                assign rgt_key = cell_key[gi+1];
                assign rgt_pay = cell_pay[gi+1];
            end

            bbks_cell u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .valid         (slot_valid),
                .left_ge       (lft_ge),
                .left_key      (lft_key),
                .left_payload  (lft_pay),
                .right_ge      (rgt_ge),
                .right_key     (rgt_key),
                .right_payload (rgt_pay),
                .cell_key      (cell_key[gi]),
                .cell_payload  (cell_pay[gi]),
                .cell_ge       (cell_ge[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        ctrl.op        = OP_HOLD;
        ctrl.key       = key_reg;
        ctrl.payload   = pay_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    out_word_next = '0;
                    if (cmd_reg == CMD_PUSH)
                    begin
                        if (count_reg < cap_reg)
                        begin
                            ctrl.op                = OP_INSERT;
                            count_next             = count_reg + CNT_W'(1);
                            out_word_next.accepted = 1'b1;
                        end
                        else if (count_reg != '0 && cell_key[0] > key_reg)
                        begin
                            ctrl.op                = OP_REPLACE;
                            out_word_next.accepted = 1'b1;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        ctrl.op                    = OP_SHIFT;
                        count_next                 = count_reg - CNT_W'(1);
                        out_word_next.item_valid   = 1'b1;
                        out_word_next.out_penalty  = cell_key[0][KEY_W-1:POS_W];
                        out_word_next.out_position = cell_key[0][POS_W-1:0];
                        out_word_next.out_payload  = cell_pay[0];
                    end
                    out_word_next.held_count = HELD_W'(count_next);
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            cap_next   = cap_limit(cfg_wr_data);
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= cap_limit(CAP_W'(16));
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= in_word.cmd;
            key_reg <= {in_word.penalty, in_word.position};
            pay_reg <= in_word.payload;
        end
        out_word_reg <= out_word_next;
    end

    // the held count never passes the capacity
    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("held count above capacity");

    // head holds the worst entry: chain stays sorted worst-first
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_key[0] >= cell_key[1]))
        else $error("cell chain out of order at the head");

    // a pop that returns an entry drops the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_done && cmd_reg == CMD_POP && count_reg != '0 && !cfg_wr_en)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not remove one entry");

    // an accepted word always moves the controller into the execute state
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted word not processed");

endmodule

// ===== hw/rtl/bbks_cell.sv =====
// one entry of the sorted chain: key, payload and the compare against the broadcast key
// depends on bbks_pkg
module bbks_cell
    import bbks_pkg::*;
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic             valid,
    input  logic             left_ge,
    input  logic [KEY_W-1:0] left_key,
    input  logic [PAY_W-1:0] left_payload,
    input  logic             right_ge,
    input  logic [KEY_W-1:0] right_key,
    input  logic [PAY_W-1:0] right_payload,
    output logic [KEY_W-1:0] cell_key,
    output logic [PAY_W-1:0] cell_payload,
    output logic             cell_ge
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [PAY_W-1:0] pay_reg;
    logic [PAY_W-1:0] pay_next;

    assign cell_ge      = valid && (key_reg >= ctrl.key);
    assign cell_key     = key_reg;
    assign cell_payload = pay_reg;

    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                // entries at or above the new key stay, the rest move one away from the head
                if (!cell_ge)
                begin
                    if (left_ge)
                    begin
                        key_next = ctrl.key;
                        pay_next = ctrl.payload;
                    end
                    else
                    begin
                        key_next = left_key;
                        pay_next = left_payload;
                    end
                end
            end
            OP_REPLACE:
            begin
                // head drops out, entries at or above the new key close up toward the head
                if (right_ge)
                begin
                    key_next = right_key;
                    pay_next = right_payload;
                end
                else if (cell_ge)
                begin
                    key_next = ctrl.key;
                    pay_next = ctrl.payload;
                end
            end
            OP_SHIFT:
            begin
                key_next = right_key;
                pay_next = right_payload;
            end
            default:
            begin
                key_next = key_reg;
                pay_next = pay_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

endmodule

// ===== verif/bounded_best_k_selector_tb.sv =====
// self-checking testbench for bounded_best_k_selector: drives push and pop words,
// predicts every result word with its own model of the kept set and checks it
// depends on bbks_pkg and the bounded_best_k_selector rtl
module bounded_best_k_selector_tb
    import bbks_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 4;
    localparam int PHASE_WORDS  = 160;

    // keeps its own copy of the kept set and the expected result words
    class selector_scoreboard;
        logic [KEY_W-1:0] key_mem[MAX_CAPACITY];
        logic [PAY_W-1:0] pay_mem[MAX_CAPACITY];
        int               held;
        int               kept_limit;
        out_word_t        pending_results[$];
        int               fail_count;

        function new();
            held       = 0;
            kept_limit = MAX_CAPACITY;
            fail_count = 0;
        endfunction

        // a write of capacity also empties the set
        function void set_capacity(logic [CAP_W-1:0] v);
            if (v == '0)
            begin
                kept_limit = 1;
            end
            else if (int'(v) > MAX_CAPACITY)
            begin
                kept_limit = MAX_CAPACITY;
            end
            else
            begin
                kept_limit = int'(v);
            end
            held = 0;
        endfunction

        // highest key wins, earliest slot among equals
        function int worst_slot();
            int w;
            w = 0;
            for (int i = 1; i < held; i++)
            begin
                if (key_mem[i] > key_mem[w])
                begin
                    w = i;
                end
            end
            return w;
        endfunction

        function void drop_slot(int idx);
            for (int i = idx; i + 1 < held; i++)
            begin
                key_mem[i] = key_mem[i + 1];
                pay_mem[i] = pay_mem[i + 1];
            end
            held--;
        endfunction

        function void note_input_word(in_word_t w);
            out_word_t        r;
            logic [KEY_W-1:0] key;
            int               slot;
            r   = '0;
            key = {w.penalty, w.position};
            if (w.cmd == CMD_PUSH)
            begin
                slot = -1;
                if (held < kept_limit)
                begin
                    slot = held;
                end
                else if (held > 0)
                begin
                    if (key < key_mem[worst_slot()])
                    begin
                        drop_slot(worst_slot());
                        slot = held;
                    end
                end
                if (slot >= 0)
                begin
                    key_mem[slot] = key;
                    pay_mem[slot] = w.payload;
                    held++;
                    r.accepted = 1'b1;
                end
            end
            else if (held > 0)
            begin
                slot           = worst_slot();
                r.item_valid   = 1'b1;
                r.out_penalty  = key_mem[slot][KEY_W-1:POS_W];
                r.out_position = key_mem[slot][POS_W-1:0];
                r.out_payload  = pay_mem[slot];
                drop_slot(slot);
            end
            r.held_count = HELD_W'(held);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result_word(out_word_t got);
            out_word_t want;
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected: %0h", got);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("item_valid", 64'(want.item_valid), 64'(got.item_valid));
            compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
            compare_field("out_penalty", 64'(want.out_penalty), 64'(got.out_penalty));
            compare_field("out_position", 64'(want.out_position), 64'(got.out_position));
            compare_field("out_payload", want.out_payload, got.out_payload);
            compare_field("held_count", 64'(want.held_count), 64'(got.held_count));
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    in_word_t         in_word;
    logic             out_valid;
    logic             out_stall;
    out_word_t        out_word;

    selector_scoreboard sb = new();

    bounded_best_k_selector dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word)
    );

    initial clk = 1'b0;
    always #10ns clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result_word(out_word);
        end
    end

    // receiver stall pattern: free, light, heavy or periodic spans
    initial
    begin
        int mode;
        int span;
        int tick;
        out_stall = 1'b0;
        tick      = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 200);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    2:       out_stall <= ($urandom_range(0, 99) < 85);
                    default: out_stall <= (tick % 7) < 3;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic in_word_t make_word(logic cmd, logic [PEN_W-1:0] pen,
                                           logic [POS_W-1:0] pos, logic [PAY_W-1:0] pay);
        in_word_t w;
        w.cmd      = cmd;
        w.penalty  = pen;
        w.position = pos;
        w.payload  = pay;
        return w;
    endfunction

    // mostly narrow keys so ties and replacements are frequent
    function automatic in_word_t random_word(int push_pct, int spread);
        logic             cmd;
        logic [PEN_W-1:0] pen;
        logic [POS_W-1:0] pos;
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        case ($urandom_range(0, 9))
            0:       pen = PEN_W'($urandom);
            1:       pen = $urandom_range(0, 1) ? '1 : '0;
            default: pen = PEN_W'($urandom_range(0, spread));
        endcase
        case ($urandom_range(0, 9))
            0:       pos = $urandom;
            1:       pos = $urandom_range(0, 1) ? '1 : '0;
            default: pos = POS_W'($urandom_range(0, spread));
        endcase
        return make_word(cmd, pen, pos, {$urandom, $urandom});
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input in_word_t w);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_input_word(w);
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        drain_results();
        repeat (SETTLE_WAIT) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_capacity(v);
    endtask

    task automatic run_phase(input int count, input int push_pct, input int spread,
                             input bit gaps);
        int burst;
        burst = $urandom_range(1, 24);
        for (int n = 0; n < count; n++)
        begin
            send_word(random_word(push_pct, spread));
            burst--;
            if (burst == 0)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    drain_results();
                end
                else if (gaps)
                begin
                    idle_cycles($urandom_range(1, 12));
                end
                burst = $urandom_range(1, 24);
            end
        end
    endtask

    initial
    begin
        int cap_plan[10];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_word     = '0;
        cap_plan    = '{31, 1, 0, 2, 17, 5, 9, 16, 3, 0};
        cap_plan[9] = $urandom_range(0, 31);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset capacity: empty pop, key extremes, equal keys pop earliest first
        send_word(make_word(CMD_POP, '0, '0, '0));
        send_word(make_word(CMD_PUSH, '1, '1, '1));
        send_word(make_word(CMD_PUSH, '0, '0, '0));
        send_word(make_word(CMD_PUSH, 16'd5, 32'd100, 64'hA));
        send_word(make_word(CMD_PUSH, 16'd5, 32'd100, 64'hB));
        repeat (5) send_word(make_word(CMD_POP, '1, '1, '1));

        // zero reads as one: worse and equal keys bounce, a better one replaces
        write_capacity(5'd0);
        send_word(make_word(CMD_PUSH, 16'd10, 32'd10, 64'h1));
        send_word(make_word(CMD_PUSH, 16'd10, 32'd11, 64'h2));
        send_word(make_word(CMD_PUSH, 16'd10, 32'd10, 64'h3));
        send_word(make_word(CMD_PUSH, 16'd9, '1, 64'h4));
        send_word(make_word(CMD_POP, '0, '0, '0));
        send_word(make_word(CMD_POP, '0, '0, '0));

        // full set with equal worst keys: the earliest one is replaced
        write_capacity(5'd2);
        send_word(make_word(CMD_PUSH, 16'd3, 32'd3, 64'h11));
        send_word(make_word(CMD_PUSH, 16'd3, 32'd3, 64'h22));
        send_word(make_word(CMD_PUSH, 16'd3, 32'd2, 64'h33));
        send_word(make_word(CMD_POP, '0, '0, '0));
        send_word(make_word(CMD_POP, '0, '0, '0));
        send_word(make_word(CMD_PUSH, 16'hAAAA, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        send_word(make_word(CMD_PUSH, 16'h5555, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555));
        send_word(make_word(CMD_POP, '0, '0, '0));
        send_word(make_word(CMD_POP, '0, '0, '0));

        foreach (cap_plan[p])
        begin
            write_capacity(cap_plan[p][CAP_W-1:0]);
            run_phase(PHASE_WORDS, $urandom_range(45, 80), $urandom_range(1, 15), p % 2 == 0);
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (sb.fail_count == 0 && sb.pending_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bbks_pkg.sv
hw/rtl/bbks_cell.sv
hw/rtl/bounded_best_k_selector.sv
verif/bounded_best_k_selector_tb.sv
